// File: design/text_mode_terminal_writer_defines.svh
// Assertion macros shared by the checker of the text-mode terminal writer
`ifndef TEXT_MODE_TERMINAL_WRITER_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define TMTW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet while in reset
`define TMTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tmtw_pkg.sv
// Shared constants, codes and controller/datapath interface types
`timescale 1ns / 1ps

package tmtw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int SCROLL_COPY = COLUMNS * (ROWS - 1);
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int SWEEP_W     = $clog2(CELL_COUNT + 1);
    localparam int TAB_SPACES  = 8;
    localparam int CNT_W       = $clog2(TAB_SPACES + 1);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LOC_W  = 11;
    localparam int IDX_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] CLEAR_CELL = 16'h0720;

    typedef enum logic {
        OP_PUT  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef struct packed {
        logic clear_step;
        logic sweep_clr;
        logic capture;
        logic put;
        logic newline;
        logic backspace;
        logic scroll_step;
        logic mem_read;
        logic load_out;
    } tmtw_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_read;
        logic is_nul;
        logic is_newline;
        logic is_backspace;
        logic put_scroll;
        logic nl_scroll;
        logic put_last;
        logic count_zero;
        logic sweep_done;
        logic out_busy;
    } tmtw_status_t;

endpackage

// File: design/tmtw_ctrl.sv
// Sequencing state machine: clear sweep, put, newline, backspace, scroll, read, deliver
`timescale 1ns / 1ps

module tmtw_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  tmtw_pkg::tmtw_status_t status,
    output tmtw_pkg::tmtw_cmd_t   cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_PUT    = 8'b0000_0100,
        S_NL     = 8'b0000_1000,
        S_BS     = 8'b0001_0000,
        S_SCROLL = 8'b0010_0000,
        S_READ   = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    priority if (status.is_read)
                    begin
                        state_next = S_READ;
                    end
                    else if (status.is_nul)
                    begin
                        state_next = S_DONE;
                    end
                    else if (status.is_newline)
                    begin
                        state_next = S_NL;
                    end
                    else if (status.is_backspace)
                    begin
                        state_next = S_BS;
                    end
                    else
                    begin
                        state_next = S_PUT;
                    end
                end
            end
            S_PUT:
            begin
                cmd.put = 1'b1;
                priority if (status.put_scroll)
                begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = S_SCROLL;
                end
                else if (status.put_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_NL:
            begin
                cmd.newline = 1'b1;
                if (status.nl_scroll)
                begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = S_SCROLL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BS:
            begin
                cmd.backspace = 1'b1;
                state_next    = S_DONE;
            end
            S_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
                if (status.sweep_done)
                begin
                    state_next = status.count_zero ? S_DONE : S_PUT;
                end
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/tmtw_datapath.sv
// Cursor registers, cell memory, sweep counter and output register
`timescale 1ns / 1ps

module tmtw_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  tmtw_pkg::tmtw_cmd_t                cmd,
    output tmtw_pkg::tmtw_status_t             status,
    input  logic                               operation,
    input  logic [tmtw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tmtw_pkg::IDX_W-1:0]         read_index,
    input  logic                               cfg_write_en,
    input  logic [tmtw_pkg::ATTR_W-1:0]        cfg_write_data,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic [tmtw_pkg::COL_W-1:0]         cursor_col,
    output logic [tmtw_pkg::ROW_W-1:0]         cursor_row,
    output logic [tmtw_pkg::LOC_W-1:0]         cursor_location,
    output logic [tmtw_pkg::CELL_W-1:0]        cell_data
);

    localparam logic [tmtw_pkg::COL_W-1:0]   LAST_COL   = tmtw_pkg::COL_W'(tmtw_pkg::COLUMNS - 1);
    localparam logic [tmtw_pkg::ROW_W-1:0]   LAST_ROW   = tmtw_pkg::ROW_W'(tmtw_pkg::ROWS - 1);
    localparam logic [tmtw_pkg::LOC_W-1:0]   SCROLL_LOC = tmtw_pkg::LOC_W'(tmtw_pkg::SCROLL_COPY);
    localparam logic [tmtw_pkg::LOC_W-1:0]   COLS_LOC   = tmtw_pkg::LOC_W'(tmtw_pkg::COLUMNS);
    localparam logic [tmtw_pkg::SWEEP_W-1:0] SWEEP_END  = tmtw_pkg::SWEEP_W'(tmtw_pkg::CELL_COUNT);
    localparam logic [tmtw_pkg::SWEEP_W-1:0] SWEEP_LAST =
        tmtw_pkg::SWEEP_W'(tmtw_pkg::CELL_COUNT - 1);
    localparam logic [tmtw_pkg::SWEEP_W-1:0] COPY_END   = tmtw_pkg::SWEEP_W'(tmtw_pkg::SCROLL_COPY);
    localparam logic [tmtw_pkg::SWEEP_W:0]   COLS_SWEEP = (tmtw_pkg::SWEEP_W + 1)'(tmtw_pkg::COLUMNS);

    logic [tmtw_pkg::ATTR_W-1:0]  attr_reg;
    logic [tmtw_pkg::COL_W-1:0]   col_reg, col_next;
    logic [tmtw_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [tmtw_pkg::LOC_W-1:0]   loc_reg, loc_next;
    logic [tmtw_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [tmtw_pkg::SWEEP_W-1:0] sweep_reg, sweep_next;
    logic [tmtw_pkg::CHAR_W-1:0]  put_ch_reg;
    logic [tmtw_pkg::IDX_W-1:0]   idx_reg;
    logic                         op_read_reg;
    logic                         in_range_reg;
    logic [tmtw_pkg::CELL_W-1:0]  rd_q_reg;

    logic                         out_valid_reg;
    logic [tmtw_pkg::COL_W-1:0]   out_col_reg;
    logic [tmtw_pkg::ROW_W-1:0]   out_row_reg;
    logic [tmtw_pkg::LOC_W-1:0]   out_loc_reg;
    logic [tmtw_pkg::CELL_W-1:0]  out_data_reg;

    logic [tmtw_pkg::CELL_W-1:0]  mem [tmtw_pkg::CELL_COUNT];
    logic                         mem_we;
    logic [tmtw_pkg::ADDR_W-1:0]  mem_wa;
    logic [tmtw_pkg::CELL_W-1:0]  mem_wd;
    logic                         mem_re;
    logic [tmtw_pkg::ADDR_W-1:0]  mem_ra;

    logic [tmtw_pkg::LOC_W-1:0]   bs_loc;
    logic [tmtw_pkg::CELL_W-1:0]  blank_cell;
    logic [tmtw_pkg::SWEEP_W-1:0] sweep_prev;
    logic [tmtw_pkg::SWEEP_W:0]   sweep_src;
    logic                         is_tab;

    assign blank_cell = {attr_reg, tmtw_pkg::CH_SPACE};
    assign bs_loc     = (col_reg != '0) ? (loc_reg - 1'b1) : loc_reg;
    assign sweep_prev = sweep_reg - 1'b1;
    assign sweep_src  = {1'b0, sweep_reg} + COLS_SWEEP;
    assign is_tab     = (char_code == tmtw_pkg::CH_TAB);

    always_comb
    begin
        status              = '0;
        status.clear_last   = (sweep_reg == SWEEP_LAST);
        status.is_read      = (tmtw_pkg::op_t'(operation) == tmtw_pkg::OP_READ);
        status.is_nul       = (char_code == tmtw_pkg::CH_NUL);
        status.is_newline   = (char_code == tmtw_pkg::CH_NEWLINE);
        status.is_backspace = (char_code == tmtw_pkg::CH_BACKSPACE);
        status.put_scroll   = (col_reg == LAST_COL) && (row_reg == LAST_ROW);
        status.nl_scroll    = (row_reg == LAST_ROW);
        status.put_last     = (count_reg == tmtw_pkg::CNT_W'(1));
        status.count_zero   = (count_reg == '0);
        status.sweep_done   = (sweep_reg == SWEEP_END);
        status.out_busy     = out_valid_reg && out_stall;
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        loc_next   = loc_reg;
        count_next = count_reg;
        if (cmd.capture)
        begin
            priority if (status.is_read || status.is_nul || status.is_newline
                         || status.is_backspace)
            begin
                count_next = '0;
            end
            else if (is_tab)
            begin
                count_next = tmtw_pkg::CNT_W'(tmtw_pkg::TAB_SPACES);
            end
            else
            begin
                count_next = tmtw_pkg::CNT_W'(1);
            end
        end
        if (cmd.put)
        begin
            count_next = count_reg - 1'b1;
            if (col_reg == LAST_COL)
            begin
                col_next = '0;
                if (row_reg == LAST_ROW)
                begin
                    loc_next = SCROLL_LOC;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    loc_next = loc_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                loc_next = loc_reg + 1'b1;
            end
        end
        if (cmd.newline)
        begin
            col_next = '0;
            if (row_reg == LAST_ROW)
            begin
                loc_next = SCROLL_LOC;
            end
            else
            begin
                row_next = row_reg + 1'b1;
                loc_next = loc_reg + (COLS_LOC - tmtw_pkg::LOC_W'(col_reg));
            end
        end
        if (cmd.backspace && (col_reg != '0))
        begin
            col_next = col_reg - 1'b1;
            loc_next = loc_reg - 1'b1;
        end
    end

    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.sweep_clr)
        begin
            sweep_next = '0;
        end
        else if (cmd.clear_step || cmd.scroll_step)
        begin
            sweep_next = sweep_reg + 1'b1;
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = blank_cell;
        mem_re = 1'b0;
        mem_ra = idx_reg[tmtw_pkg::ADDR_W-1:0];
        priority if (cmd.clear_step)
        begin
            mem_we = 1'b1;
            mem_wa = sweep_reg[tmtw_pkg::ADDR_W-1:0];
            mem_wd = tmtw_pkg::CLEAR_CELL;
        end
        else if (cmd.put)
        begin
            mem_we = 1'b1;
            mem_wa = loc_reg[tmtw_pkg::ADDR_W-1:0];
            mem_wd = {attr_reg, put_ch_reg};
        end
        else if (cmd.backspace)
        begin
            mem_we = 1'b1;
            mem_wa = bs_loc[tmtw_pkg::ADDR_W-1:0];
            mem_wd = blank_cell;
        end
        else if (cmd.scroll_step)
        begin
            mem_we = (sweep_reg != '0);
            mem_wa = sweep_prev[tmtw_pkg::ADDR_W-1:0];
            mem_wd = (sweep_reg <= COPY_END) ? rd_q_reg : blank_cell;
            mem_re = (sweep_reg < COPY_END);
            mem_ra = sweep_src[tmtw_pkg::ADDR_W-1:0];
        end
        else if (cmd.mem_read)
        begin
            mem_re = in_range_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_q_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg      <= tmtw_pkg::RESET_ATTR;
            col_reg       <= '0;
            row_reg       <= '0;
            loc_reg       <= '0;
            count_reg     <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                attr_reg <= cfg_write_data;
            end
            col_reg   <= col_next;
            row_reg   <= row_next;
            loc_reg   <= loc_next;
            count_reg <= count_next;
            sweep_reg <= sweep_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            put_ch_reg   <= is_tab ? tmtw_pkg::CH_SPACE : char_code;
            idx_reg      <= read_index;
            op_read_reg  <= status.is_read;
            in_range_reg <= (read_index < tmtw_pkg::IDX_W'(tmtw_pkg::CELL_COUNT));
        end
        if (cmd.load_out)
        begin
            out_col_reg  <= col_reg;
            out_row_reg  <= row_reg;
            out_loc_reg  <= loc_reg;
            out_data_reg <= (op_read_reg && in_range_reg) ? rd_q_reg : '0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign cursor_col      = out_col_reg;
    assign cursor_row      = out_row_reg;
    assign cursor_location = out_loc_reg;
    assign cell_data       = out_data_reg;

endmodule

// File: design/text_mode_terminal_writer.sv
// Top level of the text-mode terminal writer
//
// Input channel (in_valid/in_stall) carries one beat per item: operation, char_code,
// read_index. Output channel (out_valid/out_stall) returns one beat per item with the
// cursor column, row and linear location after the item, and cell_data for a read.
// colour_attr is written through cfg_write_en/cfg_write_data; the user is to write it
// only while the block is idle, as the block itself has no guard for this. Items pass
// one at a time through the controller; a new item is taken only after the last is
// loaded into the output register. A tab makes eight cell writes on the single memory
// write port. Any put or newline that scrolls adds a row-up copy through the one-read,
// one-write cell memory followed by the blank bottom row.
// Reset: the cursor returns to 0,0, colour_attr to 0x07, and a clearing pass writes
// 0x0720 into every cell, one cell per cycle; in_stall stays high during the pass.
// When the receiver stalls, the result beat holds in the output register; the next item
// is still accepted and worked, and waits for the register to empty before delivery.
`timescale 1ns / 1ps

module text_mode_terminal_writer
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               operation,
    input  logic [tmtw_pkg::CHAR_W-1:0]        char_code,
    input  logic [tmtw_pkg::IDX_W-1:0]         read_index,
    input  logic                               cfg_write_en,
    input  logic [tmtw_pkg::ATTR_W-1:0]        cfg_write_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [tmtw_pkg::COL_W-1:0]         cursor_col,
    output logic [tmtw_pkg::ROW_W-1:0]         cursor_row,
    output logic [tmtw_pkg::LOC_W-1:0]         cursor_location,
    output logic [tmtw_pkg::CELL_W-1:0]        cell_data
);

    tmtw_pkg::tmtw_cmd_t    cmd;
    tmtw_pkg::tmtw_status_t status;

    tmtw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tmtw_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .operation       (operation),
        .char_code       (char_code),
        .read_index      (read_index),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .cursor_col      (cursor_col),
        .cursor_row      (cursor_row),
        .cursor_location (cursor_location),
        .cell_data       (cell_data)
    );

endmodule

// File: design/tmtw_checker.sv
// Port-level checker for the text-mode terminal writer, bound to the top level
`timescale 1ns / 1ps
`include "text_mode_terminal_writer_defines.svh"

module tmtw_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [tmtw_pkg::COL_W-1:0]         cursor_col,
    input logic [tmtw_pkg::ROW_W-1:0]         cursor_row,
    input logic [tmtw_pkg::LOC_W-1:0]         cursor_location,
    input logic [tmtw_pkg::CELL_W-1:0]        cell_data
);

    `TMTW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cursor_col) && $stable(cursor_row) && $stable(cursor_location) && $stable(cell_data), "stalled result beat changed")

    `TMTW_ASSERT_NOW(a_cursor_range, out_valid, (32'(cursor_col) < tmtw_pkg::COLUMNS) && (32'(cursor_row) < tmtw_pkg::ROWS), "cursor outside the screen")

    `TMTW_ASSERT_NOW(a_location, out_valid, 32'(cursor_location) == 32'(cursor_row) * tmtw_pkg::COLUMNS + 32'(cursor_col), "cursor location disagrees with row and column")

    `TMTW_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken again while an item is in work")

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (.*);
